// ===== design/periodic_frame_scheduler_assert.svh =====
// assertion macros used by the scheduler checker
`ifndef PERIODIC_FRAME_SCHEDULER_ASSERT_SVH
`define PERIODIC_FRAME_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PFS_AST_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset too
`define PFS_AST_NXT(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== design/pfs_pkg.sv =====
// shared types and constants of the periodic frame scheduler
package pfs_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_ENABLE = 3'd4;
  localparam logic [2:0] CMD_START  = 3'd5;
  localparam logic [2:0] CMD_STOP   = 3'd6;
  localparam logic [2:0] CMD_CLEAR  = 3'd7;

  // one table entry
  typedef struct packed {
    logic        en;
    logic [15:0] period;
    logic [31:0] last;
    logic [31:0] sends;
    logic [28:0] ident;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] payload;
  } rec_t;

  // per-cell update controls
  typedef struct packed {
    logic shift;
    logic load;
    logic keep_stats;
    logic set_en;
    logic en_val;
    logic rearm;
  } cell_ctrl_t;

endpackage

// ===== design/pfs_cell.sv =====
// one entry cell of the scheduler table chain
module pfs_cell
  import pfs_pkg::*;
(
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic [31:0] now_ms,
  input  rec_t        nb,
  input  rec_t        load_rec,
  output rec_t        rec
);

  // entry register update
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      rec <= nb;
    end else if (ctrl.load) begin
      rec.en      <= load_rec.en;
      rec.period  <= load_rec.period;
      rec.ident   <= load_rec.ident;
      rec.ext     <= load_rec.ext;
      rec.len     <= load_rec.len;
      rec.payload <= load_rec.payload;
      if (!ctrl.keep_stats) begin
        rec.last  <= now_ms;
        rec.sends <= 32'd0;
      end
    end else if (ctrl.set_en) begin
      rec.en <= ctrl.en_val;
      if (ctrl.en_val) begin
        rec.last <= now_ms;
      end
    end else if (ctrl.rearm) begin
      rec.last <= now_ms;
    end
  end

endmodule

// ===== design/periodic_frame_scheduler.sv =====
// Periodic frame scheduler: table of ENTRIES periodic frames held in a chain of cells.
// Edit commands (add, update, remove, enable, start, stop, clear) take effect when accepted.
// A tick while running goes through the transfer, one scan step per entry and a flush
// step, held while the output stalls; one entry is checked per cycle when not stalled.
// Reset (synchronous, rst high) stops the scheduler and empties the table.
module periodic_frame_scheduler
  import pfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [31:0] now_ms,
  input  logic [3:0]  slot,
  input  logic        enable_flag,
  input  logic [15:0] period_ms,
  input  logic [28:0] frame_id,
  input  logic        frame_ext,
  input  logic [3:0]  frame_dlc,
  input  logic [63:0] frame_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  sent_slot,
  output logic [28:0] out_id,
  output logic        out_ext,
  output logic [3:0]  out_dlc,
  output logic [63:0] out_data,
  output logic [31:0] sent_total,
  output logic        last_of_tick
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state;
  logic             running;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  logic [31:0]      now_q;

  rec_t       cell_q   [ENTRIES];
  rec_t       nb_rec   [ENTRIES];
  cell_ctrl_t ctrl     [ENTRIES];
  rec_t       load_rec;
  rec_t       head;
  rec_t       head_next;
  logic       head_due;
  logic       accept;
  logic       slot_ok;
  logic       step;
  logic       out_free;

  // pending result, held until the next one shows whether it is the last
  logic        pend_valid;
  logic [3:0]  pend_slot;
  rec_t        pend_rec;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot_ok  = 32'(slot) < 32'(count);
  assign out_free = !out_valid || out_ready;

  // record built from input fields
  always_comb begin
    load_rec         = '0;
    load_rec.en      = enable_flag;
    load_rec.period  = period_ms;
    load_rec.ident   = frame_id;
    load_rec.ext     = frame_ext;
    load_rec.len     = frame_dlc;
    load_rec.payload = frame_data;
  end

  // head check and re-arm
  assign head = cell_q[0];
  assign head_due = head.en && (head.period != 16'd0) &&
                    ((now_q - head.last) >= {16'd0, head.period}) &&
                    (32'(pos) < 32'(count));
  always_comb begin
    head_next = head;
    if (head_due) begin
      head_next.last  = now_q;
      head_next.sends = head.sends + 32'd1;
    end
  end

  // a step stalls only when a due entry meets a full pending slot and a busy output
  assign step = (state == ST_SCAN) && !(head_due && pend_valid && !out_free);

  // cell controls and neighbor links
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_tail
      assign nb_rec[i] = head_next;
    end else begin : g_mid
      assign nb_rec[i] = cell_q[i+1];
    end

    always_comb begin
      ctrl[i]        = '0;
      ctrl[i].en_val = enable_flag;
      if (step) begin
        ctrl[i].shift = 1'b1;
      end else if (accept) begin
        case (command)
          CMD_ADD: begin
            ctrl[i].load = (32'(i) == 32'(count)) && (32'(count) < ENTRIES);
          end
          CMD_UPDATE: begin
            ctrl[i].load       = slot_ok && (32'(i) == 32'(slot));
            ctrl[i].keep_stats = 1'b1;
          end
          CMD_REMOVE: begin
            ctrl[i].shift = slot_ok && (32'(i) >= 32'(slot)) && (i < ENTRIES - 1);
          end
          CMD_ENABLE: begin
            ctrl[i].set_en = slot_ok && (32'(i) == 32'(slot));
          end
          CMD_START: begin
            ctrl[i].rearm = !running && (32'(i) < 32'(count));
          end
          default: begin
          end
        endcase
      end
    end

    pfs_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .now_ms   (now_ms),
      .nb       (nb_rec[i]),
      .load_rec (load_rec),
      .rec      (cell_q[i])
    );
  end

  // control, scan sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      running    <= 1'b0;
      count      <= '0;
      pos        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            now_q <= now_ms;
            pos   <= '0;
            case (command)
              CMD_TICK: begin
                if (running) begin
                  state <= ST_SCAN;
                end
              end
              CMD_ADD: begin
                if (32'(count) < ENTRIES) begin
                  count <= count + 1'b1;
                end
              end
              CMD_REMOVE: begin
                if (slot_ok) begin
                  count <= count - 1'b1;
                end
              end
              CMD_START: running <= 1'b1;
              CMD_STOP:  running <= 1'b0;
              CMD_CLEAR: count   <= '0;
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (head_due) begin
              if (pend_valid) begin
                out_valid    <= 1'b1;
                sent_slot    <= pend_slot;
                out_id       <= pend_rec.ident;
                out_ext      <= pend_rec.ext;
                out_dlc      <= pend_rec.len;
                out_data     <= pend_rec.payload;
                sent_total   <= pend_rec.sends;
                last_of_tick <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_slot  <= 4'(pos);
              pend_rec   <= head_next;
            end
            if (32'(pos) == ENTRIES - 1) begin
              state <= ST_FLUSH;
            end
            pos <= pos + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            sent_slot    <= pend_slot;
            out_id       <= pend_rec.ident;
            out_ext      <= pend_rec.ext;
            out_dlc      <= pend_rec.len;
            out_data     <= pend_rec.payload;
            sent_total   <= pend_rec.sends;
            last_of_tick <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/pfs_checker.sv =====
// port-level checks of the periodic frame scheduler and their binding
`include "periodic_frame_scheduler_assert.svh"

module pfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [28:0] out_id,
  input logic        last_of_tick
);

  // a stalled result stays offered
  `PFS_AST_IMP(a_out_hold, clk, rst, out_valid && !out_ready, ##1 out_valid)
  // a stalled result keeps its identifier
  `PFS_AST_IMP(a_out_stable, clk, rst, out_valid && !out_ready, ##1 $stable(out_id))
  // no new command is taken while a tick still has results to come
  `PFS_AST_IMP(a_tick_busy, clk, rst, out_valid && !last_of_tick, !in_ready)
  // reset leaves no result offered
  `PFS_AST_NXT(a_rst_empty, clk, rst, !out_valid)

endmodule

bind periodic_frame_scheduler pfs_checker u_pfs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_id       (out_id),
  .last_of_tick (last_of_tick)
);

// ===== tb/periodic_frame_scheduler_tb.sv =====
// self-checking testbench for the periodic frame scheduler
module periodic_frame_scheduler_tb;
  import pfs_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  command;
  logic [31:0] now_ms;
  logic [3:0]  slot;
  logic        enable_flag;
  logic [15:0] period_ms;
  logic [28:0] frame_id;
  logic        frame_ext;
  logic [3:0]  frame_dlc;
  logic [63:0] frame_data;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  sent_slot;
  logic [28:0] out_id;
  logic        out_ext;
  logic [3:0]  out_dlc;
  logic [63:0] out_data;
  logic [31:0] sent_total;
  logic        last_of_tick;

  // one expected transmitted frame
  typedef struct packed {
    logic [3:0]  slot_idx;
    logic [28:0] ident;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] payload;
    logic [31:0] sends;
    logic        last;
  } tx_frame_t;

  tx_frame_t pending_frames[$];
  rec_t      sched_table[ENTRIES];
  logic      sched_running;
  int        sched_count;
  int        error_count;
  int        frames_seen;
  int        items_sent;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;
  longint    cycle_count;
  logic [31:0] clock_ms;

  periodic_frame_scheduler dut (.*);

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("periodic_frame_scheduler_tb: done, errors");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // predictor: apply one command to the shadow table, queue the frames it sends
  task automatic predict_command(input logic [2:0] cmd, input logic [31:0] t,
                                 input logic [3:0] idx, input logic en,
                                 input logic [15:0] per, input logic [28:0] id,
                                 input logic ext, input logic [3:0] dlc,
                                 input logic [63:0] data);
    int n;
    int first_q;
    tx_frame_t f;
    n = 0;
    first_q = pending_frames.size();
    case (cmd)
      CMD_TICK: begin
        if (sched_running) begin
          for (int i = 0; i < sched_count; i++) begin
            if (sched_table[i].en && sched_table[i].period != 0 &&
                (t - sched_table[i].last) >= {16'd0, sched_table[i].period}) begin
              sched_table[i].last = t;
              sched_table[i].sends = sched_table[i].sends + 32'd1;
              f.slot_idx = i[3:0];
              f.ident = sched_table[i].ident;
              f.ext = sched_table[i].ext;
              f.len = sched_table[i].len;
              f.payload = sched_table[i].payload;
              f.sends = sched_table[i].sends;
              f.last = 1'b0;
              pending_frames = {pending_frames, f};
              n++;
            end
          end
          if (n > 0) pending_frames[first_q + n - 1].last = 1'b1;
        end
      end
      CMD_ADD: begin
        if (sched_count < ENTRIES) begin
          sched_table[sched_count] = '{en: en, period: per, last: t, sends: 32'd0,
                                       ident: id, ext: ext, len: dlc, payload: data};
          sched_count++;
        end
      end
      CMD_UPDATE: begin
        if (idx < sched_count) begin
          sched_table[idx].en = en;
          sched_table[idx].period = per;
          sched_table[idx].ident = id;
          sched_table[idx].ext = ext;
          sched_table[idx].len = dlc;
          sched_table[idx].payload = data;
        end
      end
      CMD_REMOVE: begin
        if (idx < sched_count) begin
          for (int i = idx; i + 1 < sched_count; i++) sched_table[i] = sched_table[i + 1];
          sched_count--;
        end
      end
      CMD_ENABLE: begin
        if (idx < sched_count) begin
          sched_table[idx].en = en;
          if (en) sched_table[idx].last = t;
        end
      end
      CMD_START: begin
        if (!sched_running) begin
          sched_running = 1'b1;
          for (int i = 0; i < sched_count; i++) sched_table[i].last = t;
        end
      end
      CMD_STOP: sched_running = 1'b0;
      default: sched_count = 0;
    endcase
  endtask

  // send one command; idles first at the current sender rate
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] t,
                              input logic [3:0] idx, input logic en,
                              input logic [15:0] per, input logic [28:0] id,
                              input logic ext, input logic [3:0] dlc,
                              input logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    now_ms      <= t;
    slot        <= idx;
    enable_flag <= en;
    period_ms   <= per;
    frame_id    <= id;
    frame_ext   <= ext;
    frame_dlc   <= dlc;
    frame_data  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(cmd, t, idx, en, per, id, ext, dlc, data);
    items_sent++;
  endtask

  task automatic send_random_frame(input logic [2:0] cmd, input logic [31:0] t,
                                   input logic [3:0] idx, input logic en,
                                   input logic [15:0] per);
    send_command(cmd, t, idx, en, per, 29'($urandom), 1'($urandom),
                 4'($urandom_range(8)), {$urandom, $urandom});
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        frames_seen++;
        if (pending_frames.size() == 0) begin
          report("unexpected frame, slot", 64'(sent_slot), 64'd0);
        end else begin
          tx_frame_t w;
          w = pending_frames.pop_front();
          if (sent_slot !== w.slot_idx)
            report("sent_slot", 64'(sent_slot), 64'(w.slot_idx));
          if (out_id !== w.ident) report("out_id", 64'(out_id), 64'(w.ident));
          if (out_ext !== w.ext) report("out_ext", 64'(out_ext), 64'(w.ext));
          if (out_dlc !== w.len) report("out_dlc", 64'(out_dlc), 64'(w.len));
          if (out_data !== w.payload) report("out_data", out_data, w.payload);
          if (sent_total !== w.sends)
            report("sent_total", 64'(sent_total), 64'(w.sends));
          if (last_of_tick !== w.last)
            report("last_of_tick", 64'(last_of_tick), 64'(w.last));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // extremes of the fields, every command, each special case
  task automatic test_directed();
    clock_ms = 32'hFFFF_FFF0;
    send_command(CMD_TICK, clock_ms, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_ADD, clock_ms, 4'd0, 1'b1, 16'd1, 29'h1FFF_FFFF, 1'b1, 4'd8, '1);
    send_command(CMD_ADD, clock_ms, 4'd0, 1'b1, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_ADD, clock_ms, 4'd0, 1'b1, 16'hFFFF, 29'h0ABC, 1'b0, 4'd15, 64'h55);
    send_command(CMD_ADD, clock_ms, 4'd0, 1'b0, 16'd2, 29'd7, 1'b1, 4'd3, 64'hAA);
    send_command(CMD_TICK, clock_ms, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_START, clock_ms, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_TICK, clock_ms, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    // time wraps past zero
    send_command(CMD_TICK, 32'd20, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_ENABLE, 32'd20, 4'd3, 1'b1, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_START, 32'd25, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_UPDATE, 32'd25, 4'd1, 1'b1, 16'd3, 29'h123, 1'b1, 4'd8, 64'h1);
    send_command(CMD_UPDATE, 32'd25, 4'd15, 1'b1, 16'd3, 29'h123, 1'b1, 4'd8, 64'h1);
    send_command(CMD_ENABLE, 32'd25, 4'd9, 1'b1, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_TICK, 32'd30, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_REMOVE, 32'd30, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_REMOVE, 32'd30, 4'd12, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_ENABLE, 32'd30, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_TICK, 32'd40, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_STOP, 32'd40, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_TICK, 32'd50, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_CLEAR, 32'd50, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_START, 32'd50, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    send_command(CMD_TICK, 32'd60, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    wait_drained();
  endtask

  // full table, all entries due on every tick, receiver held off
  task automatic test_full_table_backpressure();
    send_command(CMD_CLEAR, clock_ms, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    for (int i = 0; i < ENTRIES + 1; i++)
      send_random_frame(CMD_ADD, clock_ms, 4'($urandom), 1'b1, 16'd1);
    hold_cycles = 300;
    for (int i = 0; i < 4; i++) begin
      clock_ms = clock_ms + 1;
      send_command(CMD_TICK, clock_ms, 4'd0, 1'b0, 16'd0, 29'd0, 1'b0, 4'd0, 64'd0);
    end
    wait_drained();
  endtask

  // random traffic: ticks (the most common command) over a live table, with edits mixed in
  task automatic test_random(input int n_items, input int idle, input int stall);
    int r;
    logic [3:0] idx;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      idx = (sched_count == 0 || $urandom_range(9) == 0) ? 4'($urandom) :
            4'($urandom_range(sched_count - 1));
      if ($urandom_range(3) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(12);
      if (r < 45)
        send_command(CMD_TICK, clock_ms, idx, 1'($urandom), 16'($urandom), 29'($urandom),
                     1'($urandom), 4'($urandom), {$urandom, $urandom});
      else if (r < 62)
        send_random_frame(CMD_ADD, clock_ms, idx, $urandom_range(3) != 0,
                          ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8)));
      else if (r < 72)
        send_random_frame(CMD_UPDATE, clock_ms, idx, $urandom_range(3) != 0,
                          ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8)));
      else if (r < 80)
        send_random_frame(CMD_REMOVE, clock_ms, idx, 1'($urandom), 16'($urandom));
      else if (r < 88)
        send_random_frame(CMD_ENABLE, clock_ms, idx, 1'($urandom), 16'($urandom));
      else if (r < 94)
        send_random_frame(CMD_START, clock_ms, idx, 1'($urandom), 16'($urandom));
      else if (r < 97)
        send_random_frame(CMD_STOP, clock_ms, idx, 1'($urandom), 16'($urandom));
      else
        send_random_frame(CMD_CLEAR, clock_ms, idx, 1'($urandom), 16'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_TICK;
    now_ms = '0;
    slot = '0;
    enable_flag = 1'b0;
    period_ms = '0;
    frame_id = '0;
    frame_ext = 1'b0;
    frame_dlc = '0;
    frame_data = '0;
    cycle_count = 0;
    error_count = 0;
    frames_seen = 0;
    items_sent = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sched_running = 1'b0;
    sched_count = 0;
    clock_ms = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_table_backpressure();
    test_random(85, 0, 0);
    test_random(85, 65, 0);
    test_random(85, 0, 65);
    test_random(85, 23, 23);

    $display("covered %0d commands and %0d transmitted frames over all idle mixes",
             items_sent, frames_seen);
    if (error_count == 0) begin
      $display("periodic_frame_scheduler_tb: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("periodic_frame_scheduler_tb: done, errors");
    end
    $finish;
  end

endmodule
